[rtl/core/nbns_pkg.sv]
package nbns_pkg;

    localparam int MAX_PACKET_BYTES = 2048;
    localparam int CNT_W            = $clog2(MAX_PACKET_BYTES + 2);

    localparam int PREFIX_LEN = 50;
    localparam int ANSWER_LEN = 62;
    localparam int NAME_FIRST = 13;
    localparam int NAME_LAST  = 44;
    localparam int NAME_CHARS = 15;

    localparam int JOB_DEPTH = 2;
    localparam int PTR_W     = $clog2(JOB_DEPTH);
    localparam int QCNT_W    = $clog2(JOB_DEPTH + 1);
    localparam int MEM_DEPTH = PREFIX_LEN * JOB_DEPTH;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int IDX_W     = $clog2(ANSWER_LEN);

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 64;

    localparam logic [CFG_AW-1:0] CFG_PRIMARY_ENABLE   = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_PRIMARY_NAME_LO  = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_PRIMARY_NAME_HI  = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_ALTERNATE_ENABLE = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_ALTERNATE_NAME_LO = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_ALTERNATE_NAME_HI = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_ANSWER_TTL       = 3'd6;

    localparam logic [63:0] NAME_LO_RESET = 64'h2020_2020_2020_2020;
    localparam logic [55:0] NAME_HI_RESET = 56'h20_2020_2020_2020;
    localparam logic [31:0] TTL_RESET     = 32'd3600;

    typedef enum logic [1:0] {
        CMP_COMPARING,
        CMP_MATCHED,
        CMP_MISMATCH
    } cmp_state_t;

    typedef struct packed {
        logic [31:0] ttl;
        logic [31:0] addr;
    } job_t;

    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        data;
    } mem_wr_t;

endpackage

[rtl/core/nbns_front.sv]
module nbns_front
    import nbns_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        pkt_byte,
    input  logic              pkt_end,
    input  logic [31:0]       dest_ipv4,
    input  logic              cfg_wr_en,
    input  logic [CFG_AW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data,
    input  logic              q_full,
    input  logic [PTR_W-1:0]  wr_bank,
    output logic              job_push,
    output job_t              job,
    output mem_wr_t           mem_wr
);

    logic             primary_enable_reg;
    logic [63:0]      primary_name_lo_reg;
    logic [55:0]      primary_name_hi_reg;
    logic             alternate_enable_reg;
    logic [63:0]      alternate_name_lo_reg;
    logic [55:0]      alternate_name_hi_reg;
    logic [31:0]      answer_ttl_reg;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       pending_reg, pending_next;
    cmp_state_t       pstate_reg, pstate_next;
    cmp_state_t       astate_reg, astate_next;
    logic             hdr_ok_reg, hdr_ok_next;

    logic             take;
    logic             in_prefix;
    logic [CNT_W-1:0] off;
    logic [3:0]       k;
    logic [7:0]       ch;
    logic             accept;

    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5a)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    function automatic logic [7:0] name_char(input logic [63:0] lo, input logic [55:0] hi,
                                             input logic [3:0] idx);
        logic [7:0]  r;
        logic [63:0] hi_ext;
        hi_ext = {8'h00, hi};
        if (idx[3] == 1'b0)
        begin
            r = lo[{idx[2:0], 3'b000} +: 8];
        end
        else
        begin
            r = hi_ext[{idx[2:0], 3'b000} +: 8];
        end
        return r;
    endfunction

    function automatic cmp_state_t cmp_step(input cmp_state_t st, input logic [7:0] c,
                                            input logic [7:0] ref_c);
        cmp_state_t r;
        r = st;
        if (st == CMP_COMPARING)
        begin
            if (fold(c) != fold(ref_c))
            begin
                r = CMP_MISMATCH;
            end
            else if (c == 8'h00)
            begin
                r = CMP_MATCHED;
            end
        end
        return r;
    endfunction

    assign full = q_full;
    assign take = push && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primary_enable_reg    <= 1'b1;
            primary_name_lo_reg   <= NAME_LO_RESET;
            primary_name_hi_reg   <= NAME_HI_RESET;
            alternate_enable_reg  <= 1'b0;
            alternate_name_lo_reg <= NAME_LO_RESET;
            alternate_name_hi_reg <= NAME_HI_RESET;
            answer_ttl_reg        <= TTL_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_PRIMARY_ENABLE:    primary_enable_reg    <= cfg_data[0];
                CFG_PRIMARY_NAME_LO:   primary_name_lo_reg   <= cfg_data;
                CFG_PRIMARY_NAME_HI:   primary_name_hi_reg   <= cfg_data[55:0];
                CFG_ALTERNATE_ENABLE:  alternate_enable_reg  <= cfg_data[0];
                CFG_ALTERNATE_NAME_LO: alternate_name_lo_reg <= cfg_data;
                CFG_ALTERNATE_NAME_HI: alternate_name_hi_reg <= cfg_data[55:0];
                CFG_ANSWER_TTL:        answer_ttl_reg        <= cfg_data[31:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        in_prefix    = count_reg < CNT_W'(PREFIX_LEN);
        off          = count_reg - CNT_W'(NAME_FIRST);
        k            = off[4:1];
        ch           = ((pending_reg - 8'h41) << 4) + (pkt_byte - 8'h41);
        pending_next = pending_reg;
        pstate_next  = pstate_reg;
        astate_next  = astate_reg;
        hdr_ok_next  = hdr_ok_reg;

        if (in_prefix)
        begin
            case (count_reg[5:0])
                6'd2:
                begin
                    if (pkt_byte[7:3] != 5'd0)
                    begin
                        hdr_ok_next = 1'b0;
                    end
                end
                6'd4, 6'd6, 6'd7, 6'd10, 6'd11, 6'd46, 6'd48:
                begin
                    if (pkt_byte != 8'h00)
                    begin
                        hdr_ok_next = 1'b0;
                    end
                end
                6'd5, 6'd49:
                begin
                    if (pkt_byte != 8'h01)
                    begin
                        hdr_ok_next = 1'b0;
                    end
                end
                6'd12:
                begin
                    if (pkt_byte != 8'd32)
                    begin
                        hdr_ok_next = 1'b0;
                    end
                end
                6'd47:
                begin
                    if (pkt_byte != 8'h20)
                    begin
                        hdr_ok_next = 1'b0;
                    end
                end
                default: ;
            endcase

            if (count_reg >= CNT_W'(NAME_FIRST) && count_reg <= CNT_W'(NAME_LAST))
            begin
                if (off[0] == 1'b0)
                begin
                    pending_next = pkt_byte;
                end
                else if (k < 4'(NAME_CHARS))
                begin
                    pstate_next = cmp_step(pstate_reg, ch,
                        name_char(primary_name_lo_reg, primary_name_hi_reg, k));
                    astate_next = cmp_step(astate_reg, ch,
                        name_char(alternate_name_lo_reg, alternate_name_hi_reg, k));
                end
                else if (ch != 8'h00)
                begin
                    hdr_ok_next = 1'b0;
                end
            end
        end

        count_next = count_reg;
        if (count_reg <= CNT_W'(MAX_PACKET_BYTES))
        begin
            count_next = count_reg + 1'b1;
        end

        accept = (count_reg >= CNT_W'(PREFIX_LEN - 1))
              && (count_reg <= CNT_W'(MAX_PACKET_BYTES - 1))
              && hdr_ok_next && (dest_ipv4 != 32'd0)
              && ((primary_enable_reg && pstate_next != CMP_MISMATCH)
                  || (alternate_enable_reg && astate_next != CMP_MISMATCH));

        if (pkt_end)
        begin
            count_next   = '0;
            pending_next = 8'h00;
            pstate_next  = CMP_COMPARING;
            astate_next  = CMP_COMPARING;
            hdr_ok_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            pending_reg <= 8'h00;
            pstate_reg  <= CMP_COMPARING;
            astate_reg  <= CMP_COMPARING;
            hdr_ok_reg  <= 1'b1;
        end
        else if (take)
        begin
            count_reg   <= count_next;
            pending_reg <= pending_next;
            pstate_reg  <= pstate_next;
            astate_reg  <= astate_next;
            hdr_ok_reg  <= hdr_ok_next;
        end
    end

    assign job_push    = take && pkt_end && accept;
    assign job.ttl     = answer_ttl_reg;
    assign job.addr    = dest_ipv4;
    assign mem_wr.en   = take && in_prefix;
    assign mem_wr.addr = MEM_AW'(wr_bank) * MEM_AW'(PREFIX_LEN) + MEM_AW'(count_reg);
    assign mem_wr.data = pkt_byte;

endmodule

[rtl/core/nbns_job_queue.sv]
module nbns_job_queue
    import nbns_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  job_t             push_job,
    input  logic             pop,
    output job_t             head,
    output logic             q_full,
    output logic             q_empty,
    output logic [PTR_W-1:0] wr_ptr,
    output logic [PTR_W-1:0] rd_ptr
);

    job_t              entry_reg [JOB_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head    = entry_reg[rd_ptr_reg];
    assign q_full  = cnt_reg == QCNT_W'(JOB_DEPTH);
    assign q_empty = cnt_reg == '0;
    assign wr_ptr  = wr_ptr_reg;
    assign rd_ptr  = rd_ptr_reg;

endmodule

[rtl/core/nbns_back.sv]
module nbns_back
    import nbns_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  mem_wr_t          mem_wr,
    input  logic             job_valid,
    input  job_t             job,
    input  logic [PTR_W-1:0] rd_bank,
    output logic             job_pop,
    output logic             empty,
    input  logic             pop,
    output logic [7:0]       resp_byte,
    output logic             resp_end
);

    logic [7:0]       mem [MEM_DEPTH];
    logic [7:0]       mem_q_reg;

    logic [IDX_W-1:0] idx_reg;
    logic             p1_valid_reg;
    logic [IDX_W-1:0] p1_idx_reg;
    logic [7:0]       p1_byte_reg;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_end_reg;

    logic             out_adv;
    logic             issue;
    logic             idx_in_prefix;
    logic [MEM_AW-1:0] rd_addr;
    logic [IDX_W-1:0] tail;
    logic [7:0]       tail_byte;
    logic [7:0]       p1_out;

    function automatic logic [7:0] fix_byte(input logic [IDX_W-1:0] idx, input logic [7:0] b);
        logic [7:0] r;
        case (idx)
            IDX_W'(2): r = 8'h85 | {6'd0, b[1], 1'b0};
            IDX_W'(3): r = {1'b0, b[6:5], 5'd0};
            IDX_W'(4), IDX_W'(5), IDX_W'(6): r = 8'h00;
            IDX_W'(7): r = 8'h01;
            default:   r = b;
        endcase
        return r;
    endfunction

    assign out_adv       = p1_valid_reg && (!out_valid_reg || pop);
    assign issue         = job_valid && (!p1_valid_reg || out_adv);
    assign idx_in_prefix = idx_reg < IDX_W'(PREFIX_LEN);
    assign rd_addr       = MEM_AW'(rd_bank) * MEM_AW'(PREFIX_LEN) + MEM_AW'(idx_reg);
    assign job_pop       = issue && (idx_reg == IDX_W'(ANSWER_LEN - 1));
    assign tail          = idx_reg - IDX_W'(PREFIX_LEN);

    always_comb
    begin
        case (tail)
            IDX_W'(0):  tail_byte = job.ttl[31:24];
            IDX_W'(1):  tail_byte = job.ttl[23:16];
            IDX_W'(2):  tail_byte = job.ttl[15:8];
            IDX_W'(3):  tail_byte = job.ttl[7:0];
            IDX_W'(5):  tail_byte = 8'h06;
            IDX_W'(7):  tail_byte = 8'h04;
            IDX_W'(8):  tail_byte = job.addr[31:24];
            IDX_W'(9):  tail_byte = job.addr[23:16];
            IDX_W'(10): tail_byte = job.addr[15:8];
            IDX_W'(11): tail_byte = job.addr[7:0];
            default:    tail_byte = 8'h00;
        endcase
    end

    assign p1_out = (p1_idx_reg < IDX_W'(PREFIX_LEN)) ? fix_byte(p1_idx_reg, mem_q_reg)
                                                       : p1_byte_reg;

    always_ff @(posedge clk)
    begin
        if (mem_wr.en)
        begin
            mem[mem_wr.addr] <= mem_wr.data;
        end
        if (issue && idx_in_prefix)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                idx_reg <= (idx_reg == IDX_W'(ANSWER_LEN - 1)) ? '0 : idx_reg + 1'b1;
            end
            if (issue)
            begin
                p1_valid_reg <= 1'b1;
            end
            else if (out_adv)
            begin
                p1_valid_reg <= 1'b0;
            end
            if (out_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            p1_idx_reg  <= idx_reg;
            p1_byte_reg <= tail_byte;
        end
        if (out_adv)
        begin
            out_byte_reg <= p1_out;
            out_end_reg  <= p1_idx_reg == IDX_W'(ANSWER_LEN - 1);
        end
    end

    assign empty     = !out_valid_reg;
    assign resp_byte = out_byte_reg;
    assign resp_end  = out_end_reg;

endmodule

[rtl/core/netbios_name_query_responder_top.sv]
// Answers NetBIOS name queries: the UDP payload enters one byte per transaction with its
// destination address, and a valid query for an enabled name produces a 62-byte positive
// response on the result side, the last byte marked by resp_end. The input takes one byte
// per cycle while full is low; each answer is emitted after its query ends, at one byte per
// cycle while pop is held, its first byte passing through the job queue, a buffer read
// register and the output register. The packet prefix is held in a two-bank buffer, so two
// answers can wait while a third packet is refused: full rises only when both banks hold
// answers not yet finished.
module netbios_name_query_responder_top
    import nbns_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        pkt_byte,
    input  logic              pkt_end,
    input  logic [31:0]       dest_ipv4,
    output logic              empty,
    input  logic              pop,
    output logic [7:0]        resp_byte,
    output logic              resp_end,
    input  logic              cfg_wr_en,
    input  logic [CFG_AW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data
);

    logic             q_full;
    logic             q_empty;
    logic [PTR_W-1:0] wr_ptr;
    logic [PTR_W-1:0] rd_ptr;
    logic             job_push;
    logic             job_pop;
    job_t             new_job;
    job_t             head_job;
    mem_wr_t          mem_wr;

    nbns_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pkt_byte  (pkt_byte),
        .pkt_end   (pkt_end),
        .dest_ipv4 (dest_ipv4),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .wr_bank   (wr_ptr),
        .job_push  (job_push),
        .job       (new_job),
        .mem_wr    (mem_wr)
    );

    nbns_job_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (new_job),
        .pop      (job_pop),
        .head     (head_job),
        .q_full   (q_full),
        .q_empty  (q_empty),
        .wr_ptr   (wr_ptr),
        .rd_ptr   (rd_ptr)
    );

    nbns_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mem_wr    (mem_wr),
        .job_valid (!q_empty),
        .job       (head_job),
        .rd_bank   (rd_ptr),
        .job_pop   (job_pop),
        .empty     (empty),
        .pop       (pop),
        .resp_byte (resp_byte),
        .resp_end  (resp_end)
    );

endmodule

[bench/netbios_name_query_responder_top_tb.sv]
module netbios_name_query_responder_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import nbns_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 7;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 16;
    localparam int TAIL_CYCLES    = 100;
    localparam int REPORT_LIMIT   = 40;

    localparam logic [119:0] FILESRV_UPPER = {56'h0, 64'h00_56_52_53_45_4C_49_46};
    localparam logic [119:0] FILESRV_LOWER = {56'h0, 64'h00_76_72_73_65_6C_69_66};
    localparam logic [119:0] FILESRV_LONG  = {56'h0, 64'h58_56_52_53_45_4C_49_46};

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } answer_byte_t;

    class answer_scoreboard;
        bit           prim_en;
        bit [63:0]    prim_lo;
        bit [55:0]    prim_hi;
        bit           alt_en;
        bit [63:0]    alt_lo;
        bit [55:0]    alt_hi;
        bit [31:0]    ttl;
        int unsigned  count;
        bit [7:0]     prefix [PREFIX_LEN];
        bit [7:0]     pending;
        cmp_state_t   prim_st;
        cmp_state_t   alt_st;
        bit           hdr_ok;
        answer_byte_t answer_bytes[$];
        int           errors;
        int           answers;
        int           bytes_checked;

        function new();
            prim_en = 1'b1;
            prim_lo = NAME_LO_RESET;
            prim_hi = NAME_HI_RESET;
            alt_en = 1'b0;
            alt_lo = NAME_LO_RESET;
            alt_hi = NAME_HI_RESET;
            ttl = TTL_RESET;
            errors = 0;
            answers = 0;
            bytes_checked = 0;
            clear_packet();
        endfunction

        function void clear_packet();
            count = 0;
            pending = 8'h00;
            prim_st = CMP_COMPARING;
            alt_st = CMP_COMPARING;
            hdr_ok = 1'b1;
        endfunction

        function void set_register(logic [CFG_AW-1:0] index, logic [CFG_DW-1:0] value);
            case (index)
                CFG_PRIMARY_ENABLE:    prim_en = value[0];
                CFG_PRIMARY_NAME_LO:   prim_lo = value;
                CFG_PRIMARY_NAME_HI:   prim_hi = value[55:0];
                CFG_ALTERNATE_ENABLE:  alt_en = value[0];
                CFG_ALTERNATE_NAME_LO: alt_lo = value;
                CFG_ALTERNATE_NAME_HI: alt_hi = value[55:0];
                CFG_ANSWER_TTL:        ttl = value[31:0];
                default: ;
            endcase
        endfunction

        function bit [7:0] fold(bit [7:0] c);
            return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
        endfunction

        function bit [7:0] name_char(bit [63:0] lo, bit [55:0] hi, int unsigned k);
            if (k < 8)
            begin
                return lo[8*k +: 8];
            end
            return hi[8*(k-8) +: 8];
        endfunction

        function cmp_state_t compare_char(cmp_state_t st, bit [7:0] c, bit [7:0] want);
            if (st != CMP_COMPARING)
            begin
                return st;
            end
            if (fold(c) != fold(want))
            begin
                return CMP_MISMATCH;
            end
            if (c == 8'h00)
            begin
                return CMP_MATCHED;
            end
            return CMP_COMPARING;
        endfunction

        function void note_byte(logic [7:0] b, logic last, logic [31:0] addr);
            int unsigned  n;
            int unsigned  k;
            int           i;
            bit [7:0]     c;
            bit [7:0]     r [ANSWER_LEN];
            bit [15:0]    flags_in;
            bit [6:0]     nm;
            bit [15:0]    flags_out;
            bit           ok;
            answer_byte_t item;
            n = count;
            if (n < PREFIX_LEN)
            begin
                prefix[n] = b;
                case (n)
                    2: if (b[7:3] != 5'd0) hdr_ok = 1'b0;
                    4, 6, 7, 10, 11, 46, 48: if (b != 8'h00) hdr_ok = 1'b0;
                    5, 49: if (b != 8'h01) hdr_ok = 1'b0;
                    12: if (b != 8'd32) hdr_ok = 1'b0;
                    47: if (b != 8'h20) hdr_ok = 1'b0;
                    default: ;
                endcase
                if (n >= NAME_FIRST && n <= NAME_LAST)
                begin
                    if (((n - NAME_FIRST) & 1) == 0)
                    begin
                        pending = b;
                    end
                    else
                    begin
                        k = (n - NAME_FIRST) >> 1;
                        c = ((pending - 8'h41) << 4) + (b - 8'h41);
                        if (k < NAME_CHARS)
                        begin
                            prim_st = compare_char(prim_st, c, name_char(prim_lo, prim_hi, k));
                            alt_st = compare_char(alt_st, c, name_char(alt_lo, alt_hi, k));
                        end
                        else if (c != 8'h00)
                        begin
                            hdr_ok = 1'b0;
                        end
                    end
                end
            end
            if (n <= MAX_PACKET_BYTES)
            begin
                count = n + 1;
            end
            if (!last)
            begin
                return;
            end
            ok = (n + 1 >= PREFIX_LEN) && (n + 1 <= MAX_PACKET_BYTES) && hdr_ok
                 && (addr != 32'h0)
                 && ((prim_en && prim_st != CMP_MISMATCH) || (alt_en && alt_st != CMP_MISMATCH));
            clear_packet();
            if (!ok)
            begin
                return;
            end
            for (i = 0; i < PREFIX_LEN; i++)
            begin
                r[i] = prefix[i];
            end
            flags_in = {prefix[2], prefix[3]};
            nm = (flags_in[10:4] & 7'h76) | 7'h50;
            flags_out = {1'b1, 4'b0000, nm, 4'b0000};
            r[2] = flags_out[15:8];
            r[3] = flags_out[7:0];
            r[4] = 8'h00;
            r[5] = 8'h00;
            r[6] = 8'h00;
            r[7] = 8'h01;
            r[50] = ttl[31:24];
            r[51] = ttl[23:16];
            r[52] = ttl[15:8];
            r[53] = ttl[7:0];
            r[54] = 8'h00;
            r[55] = 8'h06;
            r[56] = 8'h00;
            r[57] = 8'h04;
            r[58] = addr[31:24];
            r[59] = addr[23:16];
            r[60] = addr[15:8];
            r[61] = addr[7:0];
            for (i = 0; i < ANSWER_LEN; i++)
            begin
                item.data = r[i];
                item.last = (i == ANSWER_LEN - 1);
                answer_bytes.push_back(item);
            end
            answers++;
        endfunction

        function void check_answer_byte(logic [7:0] data, logic last);
            answer_byte_t want;
            if (answer_bytes.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                begin
                    $display("%0t: unexpected response byte, expected none, actual %02h end %0b",
                             $time, data, last);
                end
                return;
            end
            want = answer_bytes.pop_front();
            bytes_checked++;
            if (data !== want.data)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                begin
                    $display("%0t: resp_byte expected %02h actual %02h",
                             $time, want.data, data);
                end
            end
            if (last !== want.last)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                begin
                    $display("%0t: resp_end expected %0b actual %0b", $time, want.last, last);
                end
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic [7:0]        pkt_byte = 8'h00;
    logic              pkt_end = 1'b0;
    logic [31:0]       dest_ipv4 = 32'h0;
    logic              empty;
    logic              pop = 1'b0;
    logic [7:0]        resp_byte;
    logic              resp_end;
    logic              cfg_wr_en = 1'b0;
    logic [CFG_AW-1:0] cfg_index = CFG_PRIMARY_ENABLE;
    logic [CFG_DW-1:0] cfg_data = '0;

    answer_scoreboard sb;
    logic [7:0]       pkt[$];
    bit               sender_gaps = 1'b1;
    bit               receiver_gaps = 1'b1;
    bit               hold_request = 1'b0;
    int               idle_cycles = 0;
    int               packets_sent = 0;
    int               bytes_in = 0;
    int               settings_applied = 0;
    int               holds_done = 0;

    netbios_name_query_responder_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pkt_byte  (pkt_byte),
        .pkt_end   (pkt_end),
        .dest_ipv4 (dest_ipv4),
        .empty     (empty),
        .pop       (pop),
        .resp_byte (resp_byte),
        .resp_end  (resp_end),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                sb.note_byte(pkt_byte, pkt_end, dest_ipv4);
                bytes_in++;
            end
            if (pop && !empty)
            begin
                sb.check_answer_byte(resp_byte, resp_end);
            end
            if ((push && !full) || (pop && !empty))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        int i;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                pop <= 1'b0;
                for (i = 0; i < HOLD_CYCLES; i++)
                begin
                    @(posedge clk);
                end
                holds_done++;
            end
            else
            begin
                pop <= !(receiver_gaps && $urandom_range(0, 99) < 10);
            end
        end
    end

    function automatic logic [31:0] host_addr();
        return $urandom_range(32'hFFFF_FFFF, 1);
    endfunction

    function automatic logic [119:0] random_name(input int lo_char, input int hi_char);
        logic [119:0] name;
        int           i;
        for (i = 0; i < NAME_CHARS; i++)
        begin
            name[8*i +: 8] = 8'($urandom_range(hi_char, lo_char));
        end
        return name;
    endfunction

    function automatic logic [119:0] vary_case(input logic [119:0] name);
        logic [7:0] ch;
        int         i;
        for (i = 0; i < NAME_CHARS; i++)
        begin
            ch = name[8*i +: 8];
            if (((ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A))
                && $urandom_range(0, 3) == 0)
            begin
                ch = ch ^ 8'h20;
            end
            else if ($urandom_range(0, 31) == 0)
            begin
                ch = ch ^ 8'h20;
            end
            name[8*i +: 8] = ch;
        end
        return name;
    endfunction

    task automatic build_query(input logic [119:0] name, input logic [7:0] suffix,
                               input int extra);
        logic [7:0] ch;
        int         i;
        pkt.delete();
        pkt.push_back(8'($urandom_range(0, 255)));
        pkt.push_back(8'($urandom_range(0, 255)));
        pkt.push_back(8'($urandom_range(0, 7)));
        pkt.push_back(8'($urandom_range(0, 255)));
        pkt.push_back(8'h00);
        pkt.push_back(8'h01);
        pkt.push_back(8'h00);
        pkt.push_back(8'h00);
        pkt.push_back(8'($urandom_range(0, 255)));
        pkt.push_back(8'($urandom_range(0, 255)));
        pkt.push_back(8'h00);
        pkt.push_back(8'h00);
        pkt.push_back(8'd32);
        for (i = 0; i <= NAME_CHARS; i++)
        begin
            ch = (i < NAME_CHARS) ? name[8*i +: 8] : suffix;
            pkt.push_back(8'h41 + ch[7:4]);
            pkt.push_back(8'h41 + ch[3:0]);
        end
        pkt.push_back(8'($urandom_range(0, 255)));
        pkt.push_back(8'h00);
        pkt.push_back(8'h20);
        pkt.push_back(8'h00);
        pkt.push_back(8'h01);
        for (i = 0; i < extra; i++)
        begin
            pkt.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_byte(input logic [7:0] data, input logic last, input logic [31:0] addr);
        if (sender_gaps && $urandom_range(0, 99) < 8)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        push <= 1'b1;
        pkt_byte <= data;
        pkt_end <= last;
        dest_ipv4 <= addr;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_packet(input logic [31:0] addr);
        int i;
        int last_idx;
        last_idx = pkt.size() - 1;
        for (i = 0; i <= last_idx; i++)
        begin
            send_byte(pkt[i], i == last_idx, (i == last_idx) ? addr : $urandom);
        end
        packets_sent++;
    endtask

    task automatic directed_query(input logic [119:0] name, input int idx,
                                  input logic [7:0] value, input logic [31:0] addr);
        build_query(name, 8'h00, 0);
        if (idx >= 0)
        begin
            pkt[idx] = value;
        end
        send_packet(addr);
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (sb.answer_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] index, input logic [CFG_DW-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        sb.set_register(index, data);
    endtask

    task automatic apply_setting(input logic pe, input logic [119:0] pname, input logic ae,
                                 input logic [119:0] aname, input logic [31:0] ttl);
        logic [63:0] junk;
        drain();
        junk = {$urandom, $urandom};
        write_reg(CFG_PRIMARY_ENABLE, {junk[63:1], pe});
        write_reg(CFG_PRIMARY_NAME_LO, pname[63:0]);
        write_reg(CFG_PRIMARY_NAME_HI, {junk[15:8], pname[119:64]});
        junk = {$urandom, $urandom};
        write_reg(CFG_ALTERNATE_ENABLE, {junk[63:1], ae});
        write_reg(CFG_ALTERNATE_NAME_LO, aname[63:0]);
        write_reg(CFG_ALTERNATE_NAME_HI, {junk[23:16], aname[119:64]});
        write_reg(CFG_ANSWER_TTL, {junk[63:32], ttl});
        cfg_wr_en <= 1'b0;
        settings_applied++;
    endtask

    initial
    begin
        logic [119:0] name;
        int           len;
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: primary name of fifteen spaces, alternate off. Every flag
        // bit that the header check allows is set so that each copied flag shows in the answer.
        name = {sb.prim_hi, sb.prim_lo};
        build_query(name, 8'h00, 0);
        pkt[0] = 8'hFF;
        pkt[1] = 8'hFF;
        pkt[2] = 8'h07;
        pkt[3] = 8'hFF;
        pkt[8] = 8'hFF;
        pkt[9] = 8'hFF;
        send_packet(32'hFFFF_FFFF);
        pkt.delete();
        pkt.push_back(8'hFF);
        send_packet(host_addr());

        // Short primary name padded with zeros, compared without regard to case, plus an
        // alternate name. The receiver holds off while the sender goes on with no idling,
        // so both answers wait and the packet after them stalls at the input.
        apply_setting(1'b1, FILESRV_UPPER, 1'b1, random_name(8'h40, 8'h5B), 32'h0);
        sender_gaps = 1'b0;
        receiver_gaps = 1'b0;
        hold_request = 1'b1;
        directed_query(FILESRV_LOWER, -1, 8'h00, host_addr());
        directed_query(FILESRV_LONG, -1, 8'h00, host_addr());
        directed_query({sb.alt_hi, sb.alt_lo}, -1, 8'h00, host_addr());
        pkt.delete();
        pkt.push_back(8'h00);
        send_packet(host_addr());
        sender_gaps = 1'b1;
        receiver_gaps = 1'b1;

        // A matching query cut short before its prefix is complete.
        build_query(vary_case(FILESRV_UPPER), 8'h00, 0);
        len = $urandom_range(20, PREFIX_LEN - 1);
        while (pkt.size() > len)
        begin
            void'(pkt.pop_back());
        end
        send_packet(host_addr());

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.answer_bytes.size() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d response bytes never arrived", $time, sb.answer_bytes.size());
        end
        $display("summary: %0d packets (%0d bytes) sent, %0d answers, %0d response bytes checked",
                 packets_sent, bytes_in, sb.answers, sb.bytes_checked);
        $display("summary: %0d register settings, %0d receiver hold-offs, %0d errors",
                 settings_applied, holds_done, sb.errors);
        if (sb.errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
